// ----- design/cfsb_pkg.sv -----
// Shared types, constants and face-table helpers for cube_face_select_bounds.
// No dependencies.
package cfsb_pkg;

  localparam int unsigned CoordW = 28;
  localparam int unsigned CompW  = CoordW + 1;
  localparam int unsigned BoundW = 21;
  localparam int unsigned DepthW = 13;
  localparam int unsigned QuoW   = 21;

  localparam logic signed [BoundW-1:0] BoundLim    = 21'sd524288;
  localparam logic signed [BoundW-1:0] BoundLimNeg = -21'sd524288;
  localparam logic [DepthW-1:0]        MinDepthRst = 13'd4;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  // axis codes: magnitude 1 x, 2 y, 3 z; sign negates
  typedef logic signed [2:0] axis_code_t;

  localparam axis_code_t FaceMap [6][3] = '{
    '{-3'sd2,  3'sd3,  3'sd1},
    '{ 3'sd2,  3'sd3, -3'sd1},
    '{ 3'sd1,  3'sd3,  3'sd2},
    '{-3'sd1,  3'sd3, -3'sd2},
    '{-3'sd2, -3'sd1,  3'sd3},
    '{-3'sd2,  3'sd1, -3'sd3}
  };

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vert_t;

  function automatic logic signed [CompW-1:0] pick_comp(
    input face_e f, input logic [1:0] col, input vert_t v);
    axis_code_t               code;
    logic signed [CompW-1:0]  val;
    logic [2:0]               fi;
    fi   = (f > FACE_NZ) ? 3'd5 : 3'(f);
    code = FaceMap[fi][(col > 2'd2) ? 2'd2 : col];
    case (code)
      3'sd1, -3'sd1: val = {v.x[CoordW-1], v.x};
      3'sd2, -3'sd2: val = {v.y[CoordW-1], v.y};
      default:       val = {v.z[CoordW-1], v.z};
    endcase
    if (code < 0) begin
      val = -val;
    end
    return val;
  endfunction

endpackage

// ----- design/cfsb_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
// Depends on cfsb_pkg.
interface cfsb_in_if import cfsb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;
  logic                     last_vertex;
  logic [2:0]               face_query;

  modport source (output valid, op, coord_x, coord_y, coord_z, last_vertex, face_query,
                  input ready);
  modport sink   (input valid, op, coord_x, coord_y, coord_z, last_vertex, face_query,
                  output ready);
endinterface

interface cfsb_out_if import cfsb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               face;
  logic signed [BoundW-1:0] s_low;
  logic signed [BoundW-1:0] s_high;
  logic signed [BoundW-1:0] t_low;
  logic signed [BoundW-1:0] t_high;
  logic [6:0]               projected;
  logic                     overflow;

  modport source (output valid, face, s_low, s_high, t_low, t_high, projected, overflow,
                  input ready);
  modport sink   (input valid, face, s_low, s_high, t_low, t_high, projected, overflow,
                  output ready);
endinterface

// ----- design/cube_face_select_bounds.sv -----
// Top level: cube face select and per-face s/t bounds.
// Depends on cfsb_pkg, cfsb_if, cfsb_vstore, cfsb_div.
//
//  channel  dir  signals                          beat
//  in_i     in   op, coord_x/y/z, last, query     valid & ready
//  out_o    out  face, s/t low/high, projected... valid & ready
//  cfg      in   cfg_we_i, cfg_data_i (min_depth) cfg_we_i
//
// A vertex, clear or op 3 beat is taken in idle; a read goes to emit, where it
// may wait for the output. A last vertex walks the store, reading and checking
// each vertex; a projected one runs 21-step dividers for s and t side by side.
// Reset clears count, sums and bounds at once; the store needs no clearing.
// in_i is ready only between operations; the result register holds until taken.
module cube_face_select_bounds import cfsb_pkg::*; #(
  parameter int unsigned MAX_VERTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DepthW-1:0] cfg_data_i,
  cfsb_in_if.sink           in_i,
  cfsb_out_if.source        out_o
);

  localparam int unsigned AW = $clog2(MAX_VERTS);
  localparam int unsigned CW = $clog2(MAX_VERTS + 1);
  localparam int unsigned SW = CoordW + $clog2(MAX_VERTS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FACE = 6'b000010,
    ST_RD   = 6'b000100,
    ST_CHK  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [DepthW-1:0] min_depth_q;
  logic [CW-1:0]     count_q, idx_q, proj_q;
  logic signed [SW-1:0] sum_x_q, sum_y_q, sum_z_q;
  logic              ovf_q, res_ovf_q;
  face_e             face_q;
  logic [CW-1:0]     res_proj_q;

  logic signed [BoundW-1:0] s_min_q [6];
  logic signed [BoundW-1:0] s_max_q [6];
  logic signed [BoundW-1:0] t_min_q [6];
  logic signed [BoundW-1:0] t_max_q [6];

  logic out_vld_q;
  logic [2:0] o_face_q;
  logic signed [BoundW-1:0] o_sl_q, o_sh_q, o_tl_q, o_th_q;
  logic [6:0] o_proj_q;
  logic o_ovf_q;

  logic  acc, full, we;
  vert_t wvert, rvert;
  logic signed [CompW-1:0] comp_a, comp_b, comp_d;
  logic  skip, div_start, div_done, div_done_t;
  logic signed [QuoW-1:0] quo_s, quo_t;
  logic [SW-1:0] ax, ay, az;
  face_e face_pick;
  logic  last_idx;

  assign in_i.ready = (state_q == ST_IDLE);
  assign acc  = in_i.valid && in_i.ready;
  assign full = (count_q == CW'(MAX_VERTS));
  assign we   = acc && (in_i.op == OP_VERTEX) && !full;
  assign wvert = '{x: in_i.coord_x, y: in_i.coord_y, z: in_i.coord_z};

  cfsb_vstore #(.Depth(MAX_VERTS), .AddrW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wvert),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rvert)
  );

  assign comp_a = pick_comp(face_q, 2'd0, rvert);
  assign comp_b = pick_comp(face_q, 2'd1, rvert);
  assign comp_d = pick_comp(face_q, 2'd2, rvert);
  assign skip   = (comp_d <= 0) || (comp_d < $signed({16'b0, min_depth_q}));
  assign div_start = (state_q == ST_CHK) && !skip;
  assign last_idx  = ((idx_q + CW'(1)) >= count_q);

  cfsb_div u_div_s (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (comp_a), .den_i (comp_d[CoordW-1:0]),
    .done_o (div_done), .quo_o (quo_s)
  );

  cfsb_div u_div_t (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (comp_b), .den_i (comp_d[CoordW-1:0]),
    .done_o (div_done_t), .quo_o (quo_t)
  );

  assign ax = sum_x_q[SW-1] ? SW'(-sum_x_q) : SW'(sum_x_q);
  assign ay = sum_y_q[SW-1] ? SW'(-sum_y_q) : SW'(sum_y_q);
  assign az = sum_z_q[SW-1] ? SW'(-sum_z_q) : SW'(sum_z_q);

  always_comb begin
    if (ax > ay && ax > az) begin
      face_pick = sum_x_q[SW-1] ? FACE_NX : FACE_PX;
    end else if (ay > az && ay > ax) begin
      face_pick = sum_y_q[SW-1] ? FACE_NY : FACE_PY;
    end else begin
      face_pick = sum_z_q[SW-1] ? FACE_NZ : FACE_PZ;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_i.op == OP_VERTEX && in_i.last_vertex) begin
            state_d = ST_FACE;
          end else if (in_i.op == OP_READ) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_FACE: state_d = ST_RD;
      ST_RD:   state_d = ST_CHK;
      ST_CHK: begin
        if (!skip) begin
          state_d = ST_DIV;
        end else if (last_idx) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_DIV: begin
        if (div_done && div_done_t) begin
          state_d = last_idx ? ST_EMIT : ST_RD;
        end
      end
      ST_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_depth_q <= MinDepthRst;
      count_q     <= '0;
      idx_q       <= '0;
      proj_q      <= '0;
      ovf_q       <= 1'b0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      out_vld_q   <= 1'b0;
      face_q      <= FACE_PZ;
      for (int f = 0; f < 6; f++) begin
        s_min_q[f] <= BoundLim;
        t_min_q[f] <= BoundLim;
        s_max_q[f] <= BoundLimNeg;
        t_max_q[f] <= BoundLimNeg;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        min_depth_q <= cfg_data_i;
      end
      if (state_q == ST_EMIT && (!out_vld_q || out_o.ready)) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            case (in_i.op)
              OP_VERTEX: begin
                if (!full) begin
                  count_q <= count_q + CW'(1);
                  sum_x_q <= sum_x_q + SW'(in_i.coord_x);
                  sum_y_q <= sum_y_q + SW'(in_i.coord_y);
                  sum_z_q <= sum_z_q + SW'(in_i.coord_z);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              OP_CLEAR: begin
                for (int f = 0; f < 6; f++) begin
                  s_min_q[f] <= BoundLim;
                  t_min_q[f] <= BoundLim;
                  s_max_q[f] <= BoundLimNeg;
                  t_max_q[f] <= BoundLimNeg;
                end
              end
              OP_READ: begin
                face_q <= (in_i.face_query > 3'd5) ? FACE_NZ : face_e'(in_i.face_query);
              end
              default: ;
            endcase
          end
        end
        ST_FACE: begin
          face_q <= face_pick;
          idx_q  <= '0;
          proj_q <= '0;
        end
        ST_CHK: begin
          if (skip) begin
            idx_q <= idx_q + CW'(1);
          end
        end
        ST_DIV: begin
          if (div_done && div_done_t) begin
            idx_q  <= idx_q + CW'(1);
            proj_q <= proj_q + CW'(1);
            if (quo_s < s_min_q[face_q]) s_min_q[face_q] <= quo_s;
            if (quo_s > s_max_q[face_q]) s_max_q[face_q] <= quo_s;
            if (quo_t < t_min_q[face_q]) t_min_q[face_q] <= quo_t;
            if (quo_t > t_max_q[face_q]) t_max_q[face_q] <= quo_t;
          end
        end
        default: ;
      endcase
      if ((state_q == ST_CHK && skip && last_idx) ||
          (state_q == ST_DIV && div_done && div_done_t && last_idx)) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        sum_x_q <= '0;
        sum_y_q <= '0;
        sum_z_q <= '0;
      end
    end
  end

  // result side-band, settled before the emit cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && acc) begin
      res_proj_q <= '0;
      res_ovf_q  <= 1'b0;
    end else if (state_q == ST_FACE) begin
      res_ovf_q  <= ovf_q;
    end
    if (state_q == ST_CHK || state_q == ST_DIV) begin
      res_proj_q <= (state_q == ST_DIV && div_done && div_done_t) ?
                    proj_q + CW'(1) : proj_q;
    end
    if (state_q == ST_EMIT && (!out_vld_q || out_o.ready)) begin
      o_face_q <= 3'(face_q);
      o_sl_q   <= s_min_q[face_q];
      o_sh_q   <= s_max_q[face_q];
      o_tl_q   <= t_min_q[face_q];
      o_th_q   <= t_max_q[face_q];
      o_proj_q <= 7'(res_proj_q);
      o_ovf_q  <= res_ovf_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.face      = o_face_q;
  assign out_o.s_low     = o_sl_q;
  assign out_o.s_high    = o_sh_q;
  assign out_o.t_low     = o_tl_q;
  assign out_o.t_high    = o_th_q;
  assign out_o.projected = o_proj_q;
  assign out_o.overflow  = o_ovf_q;

endmodule

// ----- design/cfsb_vstore.sv -----
// Vertex store: single-port write, one registered read port.
// Depends on cfsb_pkg.
module cfsb_vstore import cfsb_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  vert_t            wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output vert_t            rdata_o
);

  vert_t mem [Depth];
  vert_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/cfsb_div.sv -----
// Restoring divider, one quotient bit a cycle: (num * 65536) / den, saturated to +/-8.0.
// Depends on cfsb_pkg.
module cfsb_div import cfsb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [CompW-1:0] num_i,
  input  logic [CoordW-1:0]       den_i,
  output logic                    done_o,
  output logic signed [QuoW-1:0]  quo_o
);

  localparam int unsigned CntW = 5;
  localparam logic [CntW-1:0] Steps = 5'd21;

  logic [CoordW-1:0] mag;
  logic [CoordW-1:0] rem_q, rem_d;
  logic [QuoW-1:0]   n_q, n_d, q_q, q_d;
  logic [CoordW-1:0] den_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d, sat_q, sat_d, neg_q, neg_d;
  logic [CoordW:0]   rem_sh;
  logic [QuoW-1:0]   qmag;

  assign mag    = num_i[CompW-1] ? CoordW'(-num_i) : CoordW'(num_i);
  assign rem_sh = {rem_q, n_q[QuoW-1]};

  always_comb begin
    rem_d  = rem_q;
    n_d    = n_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    neg_d  = neg_q;
    if (start_i) begin
      rem_d  = {5'b0, mag[CoordW-1:5]};
      n_d    = {mag[4:0], 16'b0};
      q_d    = '0;
      cnt_d  = Steps;
      busy_d = 1'b1;
      sat_d  = {5'b0, mag} >= {den_i, 5'b0};
      neg_d  = num_i[CompW-1];
    end else if (busy_q) begin
      n_d = {n_q[QuoW-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = CoordW'(rem_sh - {1'b0, den_q});
        q_d   = {q_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[CoordW-1:0];
        q_d   = {q_q[QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    n_q   <= n_d;
    q_q   <= q_d;
    sat_q <= sat_d;
    neg_q <= neg_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign qmag   = (sat_q || q_q > QuoW'(BoundLim)) ? QuoW'(BoundLim) : q_q;
  assign quo_o  = neg_q ? -$signed(qmag) : $signed(qmag);
  assign done_o = done_q;

endmodule
